// ----- src/sdpa_pkg.sv -----
// Shared types and constants for the sampled dot-plot accumulator.
// No dependencies; imported by sdpa_div, the top level and the testbench.
package sdpa_pkg;

    // Command codes carried on the input channel
    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_SAMPLE = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    // Configuration register indexes
    localparam int REG_BLOCK_SIZE = 0;
    localparam int REG_GRID_SIZE  = 1;

    // Register and field widths
    localparam int BS_W   = 17;
    localparam int GS_W   = 7;
    localparam int GRAY_W = 8;
    localparam int OUT_W  = 16;

    // Pixel scaling: gray = floor((510*c + m) / (2*m)), clipped at 255
    localparam int GRAY_SCALE = 510;
    localparam logic [GRAY_W-1:0] GRAY_MAX = 8'hFF;
    localparam logic [OUT_W-1:0]  OUT_COUNT_MAX = 16'hFFFF;

endpackage

// ----- src/sdpa_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module sdpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and read one entry a cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/sdpa_div.sv -----
// Iterative divider for the pixel gray level: one quotient bit a cycle,
// quotient clipped at 255. Depends on sdpa_pkg.
module sdpa_div
    import sdpa_pkg::*;
#(
    parameter int NW   = 26,
    parameter int DENW = 17
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [NW-1:0]     num,
    input  logic [DENW-1:0]   den,
    output logic              done,
    output logic [GRAY_W-1:0] quot
);

    localparam int DSW = DENW + GRAY_W;
    localparam int XW  = (NW > DSW) ? NW : DSW;
    localparam int SW  = $clog2(GRAY_W);

    logic              busy_reg, busy_next;
    logic              chk_reg, chk_next;
    logic              done_reg, done_next;
    logic [SW-1:0]     step_reg, step_next;
    logic [NW-1:0]     rem_reg, rem_next;
    logic [DSW-1:0]    dsh_reg, dsh_next;
    logic [GRAY_W-1:0] q_reg, q_next;
    logic              ge;

    assign ge = XW'(rem_reg) >= XW'(dsh_reg);

    // Check for clipping first, then one restoring step a cycle
    always_comb begin
        busy_next = busy_reg;
        chk_next  = chk_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        if (start) begin
            busy_next = 1'b1;
            chk_next  = 1'b1;
            rem_next  = num;
            dsh_next  = {den, {GRAY_W{1'b0}}};
            q_next    = '0;
        end else if (busy_reg) begin
            if (chk_reg) begin
                if (ge) begin
                    q_next    = GRAY_MAX;
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end else begin
                    chk_next  = 1'b0;
                    dsh_next  = dsh_reg >> 1;
                    step_next = SW'(GRAY_W - 1);
                end
            end else begin
                if (ge) begin
                    rem_next = NW'(XW'(rem_reg) - XW'(dsh_reg));
                end
                q_next   = {q_reg[GRAY_W-2:0], ge};
                dsh_next = dsh_reg >> 1;
                if (step_reg == '0) begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end else begin
                    step_next = step_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            chk_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            chk_reg  <= chk_next;
            done_reg <= done_next;
        end
        step_reg <= step_next;
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        q_reg    <= q_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// ----- src/sampled_dot_plot_accumulator.sv -----
// Top level of the sampled dot-plot accumulator: sequencer, byte store,
// count store and gray divider. Depends on sdpa_pkg, sdpa_ram, sdpa_div.
//
//   channel | ports             | beat
//   --------+-------------------+-----------------------------------------
//   input   | s_valid / s_ready | cmd, byte_addr, byte_value, x, y, offsets
//   result  | m_valid / m_ready | matched, out_of_range, cell_count, gray
//   config  | APB (psel..)      | block_size at 0x0, grid_size at 0x4
//
// Clear sweeps the count store one cell a cycle.
// After reset the same sweep runs, with s_ready low.
// One beat is worked at a time; the next is taken while a result waits.
// The count store's single read and write port sets the sample length.
module sampled_dot_plot_accumulator
    import sdpa_pkg::*;
#(
    parameter int DATA_DEPTH = 65536,
    parameter int GRID_MAX   = 64,
    parameter int COUNT_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [15:0] s_byte_addr,
    input  logic [7:0]  s_byte_value,
    input  logic [5:0]  s_block_x,
    input  logic [5:0]  s_block_y,
    input  logic [15:0] s_offset_a,
    input  logic [15:0] s_offset_b,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_matched,
    output logic        m_out_of_range,
    output logic [15:0] m_cell_count,
    output logic [7:0]  m_gray
);

    localparam int CB    = COUNT_BITS;
    localparam int GW    = $clog2(GRID_MAX);
    localparam int CELLS = GRID_MAX * GRID_MAX;
    localparam int CI    = $clog2(CELLS);
    localparam int DW    = $clog2(DATA_DEPTH);
    localparam int AW    = 25;
    localparam int NGW   = 11;
    localparam int NW    = CB + 10;
    localparam int DENW  = CB + 1;
    localparam int CW    = (CB > OUT_W) ? CB : OUT_W;
    localparam logic [AW-1:0]  DEPTH_LIM = AW'(DATA_DEPTH);
    localparam logic [NGW-1:0] GRID_LIM  = NGW'(GRID_MAX);
    localparam logic [CI-1:0]  LAST_CELL = CI'(CELLS - 1);

    typedef enum logic [9:0] {
        ST_CLR  = 10'b00_0000_0001,
        ST_IDLE = 10'b00_0000_0010,
        ST_DEC  = 10'b00_0000_0100,
        ST_RDB  = 10'b00_0000_1000,
        ST_CMP  = 10'b00_0001_0000,
        ST_CY   = 10'b00_0010_0000,
        ST_CX   = 10'b00_0100_0000,
        ST_GRD  = 10'b00_1000_0000,
        ST_DIV  = 10'b01_0000_0000,
        ST_FIN  = 10'b10_0000_0000
    } state_t;

    // Saturating increment of a count
    function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] c,
                                              input logic [1:0] inc);
        logic [CB:0] s;
        s = {1'b0, c} + (CB+1)'(inc);
        return s[CB] ? {CB{1'b1}} : s[CB-1:0];
    endfunction

    // Clip a count to the output field
    function automatic logic [OUT_W-1:0] clip_out(input logic [CB-1:0] c);
        logic [CW-1:0] e;
        e = CW'(c);
        return (e > CW'(OUT_COUNT_MAX)) ? OUT_COUNT_MAX : e[OUT_W-1:0];
    endfunction

    state_t state_reg, state_next;
    cmd_t   cmd_reg, cmd_next;

    logic [BS_W-1:0] block_size_reg;
    logic [GS_W-1:0] grid_size_reg;

    logic [15:0]       addr_reg, addr_next;
    logic [7:0]        val_reg, val_next;
    logic [5:0]        x_reg, x_next;
    logic [5:0]        y_reg, y_next;
    logic [15:0]       oa_reg, oa_next;
    logic [15:0]       ob_reg, ob_next;
    logic [7:0]        byte_a_reg, byte_a_next;
    logic              matched_reg, matched_next;
    logic              oor_reg, oor_next;
    logic [CB-1:0]     cnt_reg, cnt_next;
    logic [GRAY_W-1:0] gray_reg, gray_next;
    logic [CB-1:0]     max_reg, max_next;
    logic [CI-1:0]     clr_idx_reg, clr_idx_next;
    logic              clr_result_reg, clr_result_next;

    logic              m_valid_reg, m_valid_next;
    logic              m_matched_reg, m_matched_next;
    logic              m_oor_reg, m_oor_next;
    logic [OUT_W-1:0]  m_cnt_reg, m_cnt_next;
    logic [GRAY_W-1:0] m_gray_reg, m_gray_next;

    logic          d_we;
    logic [DW-1:0] d_waddr, d_raddr;
    logic [7:0]    d_wdata, d_rdata;
    logic          c_we;
    logic [CI-1:0] c_waddr, c_raddr;
    logic [CB-1:0] c_wdata, c_rdata;

    logic              div_start, div_done;
    logic [NW-1:0]     div_num;
    logic [DENW-1:0]   div_den;
    logic [GRAY_W-1:0] div_quot;

    logic [BS_W-1:0] bs_eff;
    logic [NGW-1:0]  n_eff;
    logic            cell_oor, byte_oor, load_oor;
    logic [AW-1:0]   ia, ib;
    logic [GW-1:0]   xg, yg;
    logic [CI-1:0]   kyx, kxy;
    logic [CB+1:0]   max3;
    logic [CB-1:0]   m_val;
    logic [CB-1:0]   nv;
    logic            cfg_wr;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_size_reg <= BS_W'(1);
            grid_size_reg  <= GS_W'(64);
        end else if (cfg_wr) begin
            if (int'(paddr[2]) == REG_BLOCK_SIZE) begin
                block_size_reg <= pwdata[BS_W-1:0];
            end else begin
                grid_size_reg <= pwdata[GS_W-1:0];
            end
        end
    end

    assign prdata = (int'(paddr[2]) == REG_BLOCK_SIZE) ? 32'(block_size_reg)
                                                       : 32'(grid_size_reg);

    // Limits, byte addresses and cell indexes of the held beat
    assign bs_eff   = (block_size_reg == '0) ? BS_W'(1) : block_size_reg;
    assign n_eff    = (NGW'(grid_size_reg) > GRID_LIM) ? GRID_LIM
                                                       : NGW'(grid_size_reg);
    assign cell_oor = (NGW'(x_reg) >= n_eff) || (NGW'(y_reg) >= n_eff);
    assign ia       = AW'(x_reg) * AW'(bs_eff) + AW'(oa_reg);
    assign ib       = AW'(y_reg) * AW'(bs_eff) + AW'(ob_reg);
    assign byte_oor = (BS_W'(oa_reg) >= bs_eff) || (BS_W'(ob_reg) >= bs_eff) ||
                      (ia >= DEPTH_LIM) || (ib >= DEPTH_LIM);
    assign load_oor = AW'(addr_reg) >= DEPTH_LIM;
    assign xg       = GW'(x_reg);
    assign yg       = GW'(y_reg);
    assign kyx      = CI'(32'(yg) * GRID_MAX + 32'(xg));
    assign kxy      = CI'(32'(xg) * GRID_MAX + 32'(yg));

    // Gray scaling terms: m = max(1, floor(3*max/4))
    assign max3    = (CB+2)'(max_reg) * (CB+2)'(3);
    assign m_val   = (max3[CB+1:2] == '0) ? CB'(1) : max3[CB+1:2];
    assign div_num = NW'(c_rdata) * NW'(GRAY_SCALE) + NW'(m_val);
    assign div_den = {m_val, 1'b0};

    // Sequencer: read, modify and write back the stores
    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        addr_next       = addr_reg;
        val_next        = val_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        oa_next         = oa_reg;
        ob_next         = ob_reg;
        byte_a_next     = byte_a_reg;
        matched_next    = matched_reg;
        oor_next        = oor_reg;
        cnt_next        = cnt_reg;
        gray_next       = gray_reg;
        max_next        = max_reg;
        clr_idx_next    = clr_idx_reg;
        clr_result_next = clr_result_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_matched_next  = m_matched_reg;
        m_oor_next      = m_oor_reg;
        m_cnt_next      = m_cnt_reg;
        m_gray_next     = m_gray_reg;
        d_we            = 1'b0;
        d_waddr         = DW'(addr_reg);
        d_wdata         = val_reg;
        d_raddr         = ia[DW-1:0];
        c_we            = 1'b0;
        c_waddr         = kyx;
        c_wdata         = '0;
        c_raddr         = kyx;
        div_start       = 1'b0;
        nv              = sat_inc(c_rdata, 2'd1);

        case (state_reg)
            ST_CLR: begin
                c_we    = 1'b1;
                c_waddr = clr_idx_reg;
                if (clr_idx_reg == LAST_CELL) begin
                    state_next = clr_result_reg ? ST_FIN : ST_IDLE;
                end else begin
                    clr_idx_next = clr_idx_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next     = cmd_t'(s_cmd);
                    addr_next    = s_byte_addr;
                    val_next     = s_byte_value;
                    x_next       = s_block_x;
                    y_next       = s_block_y;
                    oa_next      = s_offset_a;
                    ob_next      = s_offset_b;
                    matched_next = 1'b0;
                    oor_next     = 1'b0;
                    cnt_next     = '0;
                    gray_next    = '0;
                    state_next   = ST_DEC;
                end
            end
            ST_DEC: begin
                case (cmd_reg)
                    CMD_LOAD: begin
                        d_we       = !load_oor;
                        oor_next   = load_oor;
                        state_next = ST_FIN;
                    end
                    CMD_CLEAR: begin
                        max_next        = '0;
                        clr_idx_next    = '0;
                        clr_result_next = 1'b1;
                        state_next      = ST_CLR;
                    end
                    CMD_SAMPLE: begin
                        if (cell_oor || byte_oor) begin
                            oor_next   = 1'b1;
                            state_next = ST_FIN;
                        end else begin
                            state_next = ST_RDB;
                        end
                    end
                    default: begin
                        if (cell_oor) begin
                            oor_next   = 1'b1;
                            state_next = ST_FIN;
                        end else begin
                            state_next = ST_GRD;
                        end
                    end
                endcase
            end
            ST_RDB: begin
                byte_a_next = d_rdata;
                d_raddr     = ib[DW-1:0];
                state_next  = ST_CMP;
            end
            ST_CMP: begin
                matched_next = (d_rdata == byte_a_reg);
                state_next   = ST_CY;
            end
            ST_CY: begin
                if (!matched_reg) begin
                    cnt_next   = c_rdata;
                    state_next = ST_FIN;
                end else if (x_reg == y_reg) begin
                    nv         = sat_inc(c_rdata, 2'd2);
                    c_we       = 1'b1;
                    c_wdata    = nv;
                    cnt_next   = nv;
                    state_next = ST_FIN;
                end else begin
                    c_we     = 1'b1;
                    c_wdata  = nv;
                    cnt_next = nv;
                    if (nv > max_reg) begin
                        max_next = nv;
                    end
                    c_raddr    = kxy;
                    state_next = ST_CX;
                end
            end
            ST_CX: begin
                c_we    = 1'b1;
                c_waddr = kxy;
                c_wdata = nv;
                if (nv > max_reg) begin
                    max_next = nv;
                end
                state_next = ST_FIN;
            end
            ST_GRD: begin
                cnt_next   = c_rdata;
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    gray_next  = div_quot;
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_matched_next = matched_reg;
                    m_oor_next     = oor_reg;
                    m_cnt_next     = clip_out(cnt_reg);
                    m_gray_next    = gray_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLR;
            clr_idx_reg    <= '0;
            clr_result_reg <= 1'b0;
            max_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_idx_reg    <= clr_idx_next;
            clr_result_reg <= clr_result_next;
            max_reg        <= max_next;
            m_valid_reg    <= m_valid_next;
        end
        cmd_reg       <= cmd_next;
        addr_reg      <= addr_next;
        val_reg       <= val_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        oa_reg        <= oa_next;
        ob_reg        <= ob_next;
        byte_a_reg    <= byte_a_next;
        matched_reg   <= matched_next;
        oor_reg       <= oor_next;
        cnt_reg       <= cnt_next;
        gray_reg      <= gray_next;
        m_matched_reg <= m_matched_next;
        m_oor_reg     <= m_oor_next;
        m_cnt_reg     <= m_cnt_next;
        m_gray_reg    <= m_gray_next;
    end

    // Byte store
    sdpa_ram #(
        .WIDTH(8),
        .DEPTH(DATA_DEPTH)
    ) u_data_ram (
        .aclk   (aclk),
        .wr_en  (d_we),
        .wr_addr(d_waddr),
        .wr_data(d_wdata),
        .rd_addr(d_raddr),
        .rd_data(d_rdata)
    );

    // Count store
    sdpa_ram #(
        .WIDTH(CB),
        .DEPTH(CELLS)
    ) u_count_ram (
        .aclk   (aclk),
        .wr_en  (c_we),
        .wr_addr(c_waddr),
        .wr_data(c_wdata),
        .rd_addr(c_raddr),
        .rd_data(c_rdata)
    );

    // Gray level divider
    sdpa_div #(
        .NW  (NW),
        .DENW(DENW)
    ) u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (div_start),
        .num    (div_num),
        .den    (div_den),
        .done   (div_done),
        .quot   (div_quot)
    );

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_matched      = m_matched_reg;
    assign m_out_of_range = m_oor_reg;
    assign m_cell_count   = m_cnt_reg;
    assign m_gray         = m_gray_reg;

endmodule

// ----- test/sampled_dot_plot_accumulator_tb.sv -----
// Self-checking testbench for the sampled dot-plot accumulator.
// Depends on sdpa_pkg and the RTL top; a built-in predictor checks every result beat.
`timescale 1ns / 100ps

module sampled_dot_plot_accumulator_tb;
    import sdpa_pkg::*;

    localparam int STORE_DEPTH = 65536;
    localparam int GRID_SIDE   = 64;
    localparam int COUNT_TOP   = 65535;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct {
        cmd_t        cmd;
        logic [15:0] byte_addr;
        logic [7:0]  byte_value;
        logic [5:0]  block_x;
        logic [5:0]  block_y;
        logic [15:0] offset_a;
        logic [15:0] offset_b;
    } command_t;

    typedef struct {
        logic        matched;
        logic        out_of_range;
        logic [15:0] cell_count;
        logic [7:0]  gray;
    } pixel_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_cmd = '0;
    logic [15:0] s_byte_addr = '0;
    logic [7:0]  s_byte_value = '0;
    logic [5:0]  s_block_x = '0, s_block_y = '0;
    logic [15:0] s_offset_a = '0, s_offset_b = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_matched, m_out_of_range;
    logic [15:0] m_cell_count;
    logic [7:0]  m_gray;

    sampled_dot_plot_accumulator dut (.*);

    always #10 aclk = ~aclk;

    // Predictor state: byte store, count grid, off-diagonal peak, registers
    logic [7:0]    byte_mem [STORE_DEPTH];
    int unsigned   count_grid [GRID_SIDE*GRID_SIDE];
    int unsigned   peak_offdiag;
    int unsigned   cfg_block_size = 1;
    int unsigned   cfg_grid_size = 64;

    // Stimulus bookkeeping
    bit            gen_written [STORE_DEPTH];
    command_t      pending_cmds [$];
    pixel_result_t expected_pixels [$];
    command_t      cur_cmd;
    int unsigned   send_idle = 0, recv_stall = 0;
    int            error_count = 0;
    int unsigned   cycle_count = 0;

    function automatic int unsigned sat_inc(int unsigned v, int unsigned inc);
        return (v + inc > COUNT_TOP) ? COUNT_TOP : v + inc;
    endfunction

    function automatic logic [7:0] pixel_level(int unsigned c, int unsigned peak);
        longint unsigned m, g;
        m = (longint'(peak) * 3) >> 2;
        if (m < 1) m = 1;
        g = (510 * longint'(c) + m) / (2 * m);
        return (g > 255) ? 8'd255 : g[7:0];
    endfunction

    // Work out the result of one accepted command and update the state
    task automatic apply_command(command_t c);
        pixel_result_t r;
        int unsigned bs, n, kyx, kxy;
        longint unsigned ia, ib;
        r = '{1'b0, 1'b0, 16'd0, 8'd0};
        bs = (cfg_block_size == 0) ? 1 : cfg_block_size;
        n = (cfg_grid_size > GRID_SIDE) ? GRID_SIDE : cfg_grid_size;
        if (c.cmd == CMD_LOAD) begin
            byte_mem[c.byte_addr] = c.byte_value;
        end else if (c.cmd == CMD_CLEAR) begin
            foreach (count_grid[i]) count_grid[i] = 0;
            peak_offdiag = 0;
        end else if (c.block_x >= n || c.block_y >= n) begin
            r.out_of_range = 1'b1;
        end else if (c.cmd == CMD_SAMPLE) begin
            ia = longint'(c.block_x) * bs + c.offset_a;
            ib = longint'(c.block_y) * bs + c.offset_b;
            if (c.offset_a >= bs || c.offset_b >= bs || ia >= STORE_DEPTH
                    || ib >= STORE_DEPTH) begin
                r.out_of_range = 1'b1;
            end else begin
                kyx = c.block_y * GRID_SIDE + c.block_x;
                kxy = c.block_x * GRID_SIDE + c.block_y;
                if (byte_mem[ia] == byte_mem[ib]) begin
                    r.matched = 1'b1;
                    if (c.block_x == c.block_y) begin
                        count_grid[kyx] = sat_inc(count_grid[kyx], 2);
                    end else begin
                        count_grid[kyx] = sat_inc(count_grid[kyx], 1);
                        count_grid[kxy] = sat_inc(count_grid[kxy], 1);
                        if (count_grid[kyx] > peak_offdiag) peak_offdiag = count_grid[kyx];
                        if (count_grid[kxy] > peak_offdiag) peak_offdiag = count_grid[kxy];
                    end
                end
                r.cell_count = 16'(count_grid[kyx]);
            end
        end else begin
            kyx = c.block_y * GRID_SIDE + c.block_x;
            r.cell_count = 16'(count_grid[kyx]);
            r.gray = pixel_level(count_grid[kyx], peak_offdiag);
        end
        expected_pixels.push_back(r);
    endtask

    // Driver: present queued commands, hold each until accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) apply_command(cur_cmd);
            if (!s_valid || s_ready) begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle) begin
                    cur_cmd = pending_cmds.pop_front();
                    s_valid      <= 1'b1;
                    s_cmd        <= cur_cmd.cmd;
                    s_byte_addr  <= cur_cmd.byte_addr;
                    s_byte_value <= cur_cmd.byte_value;
                    s_block_x    <= cur_cmd.block_x;
                    s_block_y    <= cur_cmd.block_y;
                    s_offset_a   <= cur_cmd.offset_a;
                    s_offset_b   <= cur_cmd.offset_b;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random back-pressure, compare each result beat in order
    always @(posedge aclk) begin
        pixel_result_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected result beat: matched=%0b oor=%0b count=%0d gray=%0d",
                                 m_matched, m_out_of_range, m_cell_count, m_gray);
                end else begin
                    e = expected_pixels.pop_front();
                    if (m_matched !== e.matched || m_out_of_range !== e.out_of_range
                            || m_cell_count !== e.cell_count || m_gray !== e.gray) begin
                        error_count++;
                        if (error_count <= 10)
                            $display("mismatch: exp m=%0b o=%0b c=%0d g=%0d, got m=%0b o=%0b c=%0d g=%0d",
                                     e.matched, e.out_of_range, e.cell_count, e.gray,
                                     m_matched, m_out_of_range, m_cell_count, m_gray);
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_reg(int idx, int unsigned value);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 3'(idx * 4); pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == REG_BLOCK_SIZE) cfg_block_size = value & 32'h1FFFF;
        else cfg_grid_size = value & 32'h7F;
    endtask

    // Wait until every command is taken and every result checked
    task automatic drain();
        while (pending_cmds.size() > 0 || s_valid || expected_pixels.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic push_load(int unsigned addr, int unsigned value);
        command_t c;
        c = '{CMD_LOAD, 16'(addr), 8'(value), 6'($urandom), 6'($urandom),
              16'($urandom), 16'($urandom)};
        gen_written[addr[15:0]] = 1'b1;
        pending_cmds.push_back(c);
    endtask

    task automatic push_other(cmd_t cmd, int unsigned x, int unsigned y);
        command_t c;
        c = '{cmd, 16'($urandom), 8'($urandom), 6'(x), 6'(y),
              16'($urandom), 16'($urandom)};
        pending_cmds.push_back(c);
    endtask

    // Value most recently queued for an address, for matching pairs
    function automatic int unsigned byte_mem_guess(int unsigned addr);
        for (int i = pending_cmds.size() - 1; i >= 0; i--)
            if (pending_cmds[i].cmd == CMD_LOAD && pending_cmds[i].byte_addr == addr)
                return pending_cmds[i].byte_value;
        return byte_mem[addr];
    endfunction

    // Queue a sample; load any byte it would read that was never written
    task automatic push_sample(int unsigned x, int unsigned y, int unsigned oa,
                               int unsigned ob);
        command_t c;
        int unsigned bs, n, ia, ib, v;
        bs = (cfg_block_size == 0) ? 1 : cfg_block_size;
        n = (cfg_grid_size > GRID_SIDE) ? GRID_SIDE : cfg_grid_size;
        ia = x * bs + oa;
        ib = y * bs + ob;
        if (x < n && y < n && oa < bs && ob < bs && ia < STORE_DEPTH && ib < STORE_DEPTH) begin
            if (!gen_written[ia]) push_load(ia, $urandom_range(3));
            if (!gen_written[ib]) begin
                v = $urandom_range(1) ? byte_mem_guess(ia) : $urandom_range(3);
                push_load(ib, v);
            end
        end
        c = '{CMD_SAMPLE, 16'($urandom), 8'($urandom), 6'(x), 6'(y), 16'(oa), 16'(ob)};
        pending_cmds.push_back(c);
    endtask

    // One random command, mostly in range
    task automatic push_random();
        int unsigned bs, n, pick, x, y, oa, ob;
        bs = (cfg_block_size == 0) ? 1 : cfg_block_size;
        n = (cfg_grid_size > GRID_SIDE) ? GRID_SIDE : cfg_grid_size;
        if (n == 0) n = 1;
        x = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(n - 1);
        y = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(n - 1);
        if ($urandom_range(3) == 0) y = x;
        oa = ($urandom_range(9) == 0) ? $urandom_range(65535)
                                      : $urandom_range((bs > 65536 ? 65536 : bs) - 1);
        ob = ($urandom_range(9) == 0) ? $urandom_range(65535)
                                      : $urandom_range((bs > 65536 ? 65536 : bs) - 1);
        pick = $urandom_range(99);
        if (pick < 15)
            push_load($urandom_range(65535),
                      $urandom_range(1) ? $urandom_range(255) : $urandom_range(3));
        else if (pick < 16) push_other(CMD_CLEAR, x, y);
        else if (pick < 70) push_sample(x, y, oa, ob);
        else push_other(CMD_READ, x, y);
    endtask

    int unsigned bs_set [7] = '{1, 0, 1024, 65536, 131071, 3, 100000};
    int unsigned gs_set [7] = '{64, 127, 64, 1, 0, 17, 2};
    int unsigned idle_set [4][2] = '{'{0, 0}, '{53, 0}, '{0, 53}, '{22, 22}};

    initial begin
        foreach (byte_mem[i]) byte_mem[i] = 8'd0;
        foreach (count_grid[i]) count_grid[i] = 0;
        peak_offdiag = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: field extremes, each command, diagonal and edge cases
        write_reg(REG_BLOCK_SIZE, 1);
        write_reg(REG_GRID_SIZE, 64);
        push_load(0, 0);
        push_load(65535, 255);
        push_load(1, 0);
        push_sample(0, 1, 0, 0);
        push_sample(0, 0, 0, 0);
        push_sample(1, 0, 0, 0);
        push_other(CMD_READ, 1, 0);
        push_other(CMD_READ, 0, 0);
        push_other(CMD_READ, 63, 63);
        push_sample(63, 0, 0, 0);
        push_sample(0, 0, 65535, 0);
        push_sample(0, 0, 0, 65535);
        push_other(CMD_CLEAR, 0, 0);
        push_other(CMD_READ, 1, 0);
        drain();

        // Grid shrink keeps the peak, out-of-grid cells flagged
        write_reg(REG_GRID_SIZE, 1);
        push_sample(1, 0, 0, 0);
        push_other(CMD_READ, 0, 0);
        push_other(CMD_READ, 0, 1);
        drain();

        // Repeated hits on a diagonal cell
        write_reg(REG_GRID_SIZE, 64);
        push_other(CMD_CLEAR, 0, 0);
        push_load(2, 8'hA5);
        for (int i = 0; i < 16; i++) push_sample(2, 2, 0, 0);
        push_other(CMD_READ, 2, 2);
        push_sample(2, 3, 0, 0);
        push_other(CMD_READ, 2, 2);
        push_other(CMD_CLEAR, 0, 0);
        drain();

        // Random phases across register settings and idling patterns
        for (int p = 0; p < 14; p++) begin
            write_reg(REG_BLOCK_SIZE, bs_set[p % 7]);
            write_reg(REG_GRID_SIZE, gs_set[(p + p / 7) % 7]);
            send_idle  = idle_set[p % 4][0];
            recv_stall = idle_set[p % 4][1];
            for (int i = 0; i < 40; i++) push_random();
            drain();
        end

        send_idle = 0;
        recv_stall = 0;
        drain();
        repeat (50) @(posedge aclk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
